/* sv/rhc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    // channel that holds the maximum
    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } t_sel;

    localparam logic [14:0] HUE_SIXTH = 15'd3840;
    localparam logic [14:0] HUE_FULL  = 15'd23040;
    localparam logic [15:0] SAT_MAX   = 16'hFFFF;

    // per-item values handed from the front end to the dividers
    typedef struct packed {
        t_sel        sel;
        logic        neg;    // hue numerator negative
        logic        gray;   // max equals min
        logic        full;   // spread equals denominator
        logic [7:0]  d;
        logic [8:0]  sum;
        logic [7:0]  denom;
        logic [11:0] t;      // 15 * |num|
    } t_prep;

    typedef struct packed {
        logic [7:0] rem;
        logic [3:0] q;
    } t_step;

    // four restoring division steps; rem_in must be below divisor
    function automatic t_step div_step(input logic [7:0] rem_in,
                                       input logic [3:0] bits_in,
                                       input logic [7:0] divisor);
        logic [8:0] trial;
        logic [7:0] rem;
        t_step      res;
        rem = rem_in;
        res = '0;
        for (int i = 3; i >= 0; i--) begin
            trial = {rem, bits_in[i]};
            if (trial >= {1'b0, divisor}) begin
                trial    = trial - {1'b0, divisor};
                res.q[i] = 1'b1;
            end else begin
                res.q[i] = 1'b0;
            end
            rem = trial[7:0];
        end
        res.rem = rem;
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/rhc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rhc_front import rhc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    output logic            o_valid,
    output t_prep           o_prep
);

    // stage A: max / min / numerator
    logic       r_a_valid;
    t_sel       r_a_sel;
    logic [7:0] r_a_mx;
    logic [7:0] r_a_mn;
    logic [8:0] r_a_num;

    logic       r_b_valid;
    t_prep      r_b_prep;

    t_sel       n_sel;
    logic [7:0] n_mx;
    logic [7:0] n_mx_rg;
    logic [7:0] n_mn;
    logic [7:0] n_mn_rg;
    logic [8:0] n_num;
    t_sel       n_sel_rg;

    always_comb begin
        n_mx_rg  = (i_green > i_red) ? i_green : i_red;
        n_sel_rg = (i_green > i_red) ? SEL_GREEN : SEL_RED;
        if (i_blue > n_mx_rg) begin
            n_mx  = i_blue;
            n_sel = SEL_BLUE;
        end else begin
            n_mx  = n_mx_rg;
            n_sel = n_sel_rg;
        end
        n_mn_rg = (i_green < i_red) ? i_green : i_red;
        n_mn    = (i_blue < n_mn_rg) ? i_blue : n_mn_rg;
        case (n_sel)
            SEL_GREEN: n_num = {1'b0, i_blue} - {1'b0, i_red};
            SEL_BLUE:  n_num = {1'b0, i_red} - {1'b0, i_green};
            default:   n_num = {1'b0, i_green} - {1'b0, i_blue};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sel <= n_sel;
        r_a_mx  <= n_mx;
        r_a_mn  <= n_mn;
        r_a_num <= n_num;
    end

    // stage B: spread, sum, denominator, scaled numerator
    t_prep      n_prep;
    logic [8:0] n_sum;
    logic [8:0] n_alt;
    logic [8:0] n_mag9;
    logic [7:0] n_mag;

    always_comb begin
        n_sum  = {1'b0, r_a_mx} + {1'b0, r_a_mn};
        n_alt  = 9'd510 - n_sum;
        n_mag9 = r_a_num[8] ? (~r_a_num + 9'd1) : r_a_num;
        n_mag  = n_mag9[7:0];
        n_prep.sel   = r_a_sel;
        n_prep.neg   = r_a_num[8];
        n_prep.d     = r_a_mx - r_a_mn;
        n_prep.gray  = (r_a_mx == r_a_mn);
        n_prep.sum   = n_sum;
        n_prep.denom = (n_sum <= 9'd255) ? n_sum[7:0] : n_alt[7:0];
        n_prep.full  = (n_prep.d == n_prep.denom);
        n_prep.t     = {n_mag, 4'b0000} - {4'b0000, n_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_prep <= n_prep;
    end

    assign o_valid = r_b_valid;
    assign o_prep  = r_b_prep;

endmodule

`default_nettype wire

/* sv/rhc_divider.sv */
`timescale 1ns / 1ps
`default_nettype none

module rhc_divider import rhc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_prep       i_prep,
    output logic             o_valid,
    output logic [14:0]      o_hue,
    output logic [15:0]      o_saturation,
    output logic [8:0]       o_lightness_sum
);

    // three division stages, then the output stage
    logic [2:0]  r_vld;
    t_prep       r_ctl  [0:2];
    logic [7:0]  r_srem [0:2];
    logic [15:0] r_sq   [0:2];
    logic [7:0]  r_hrem [0:2];
    logic [11:0] r_hq   [0:2];

    logic        r_out_valid;
    logic [14:0] r_hue;
    logic [15:0] r_sat;
    logic [8:0]  r_sum;

    t_step s_st [0:3];
    t_step h_st [0:2];

    always_comb begin
        // saturation: d * 65536 / denom, d below denom unless full
        s_st[0] = div_step(i_prep.d, 4'b0000, i_prep.denom);
        s_st[1] = div_step(r_srem[0], 4'b0000, r_ctl[0].denom);
        s_st[2] = div_step(r_srem[1], 4'b0000, r_ctl[1].denom);
        s_st[3] = div_step(r_srem[2], 4'b0000, r_ctl[2].denom);
        // hue: (15*|num|) * 256 / d, quotient fits in 12 bits
        h_st[0] = div_step(i_prep.t[11:4], i_prep.t[3:0], i_prep.d);
        h_st[1] = div_step(r_hrem[0], 4'b0000, r_ctl[0].d);
        h_st[2] = div_step(r_hrem[1], 4'b0000, r_ctl[1].d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl[0]  <= i_prep;
        r_srem[0] <= s_st[0].rem;
        r_sq[0]   <= {12'd0, s_st[0].q};
        r_hrem[0] <= h_st[0].rem;
        r_hq[0]   <= {8'd0, h_st[0].q};
        r_ctl[1]  <= r_ctl[0];
        r_srem[1] <= s_st[1].rem;
        r_sq[1]   <= {r_sq[0][11:0], s_st[1].q};
        r_hrem[1] <= h_st[1].rem;
        r_hq[1]   <= {r_hq[0][7:0], h_st[1].q};
        r_ctl[2]  <= r_ctl[1];
        r_srem[2] <= s_st[2].rem;
        r_sq[2]   <= {r_sq[1][11:0], s_st[2].q};
        r_hrem[2] <= h_st[2].rem;
        r_hq[2]   <= {r_hq[1][7:0], h_st[2].q};
    end

    // floor for a negative numerator, sector offset, wrap
    logic [12:0]        n_mag;
    logic [14:0]        n_offset;
    logic signed [16:0] n_hs;
    logic signed [16:0] n_hw;
    logic [14:0]        n_hue;
    logic [15:0]        n_sat;

    always_comb begin
        n_mag = {1'b0, r_hq[2]} + {12'd0, (r_hrem[2] != 8'd0)};
        case (r_ctl[2].sel)
            SEL_GREEN: n_offset = {HUE_SIXTH[13:0], 1'b0};
            SEL_BLUE:  n_offset = {HUE_SIXTH[12:0], 2'b00};
            default:   n_offset = 15'd0;
        endcase
        if (r_ctl[2].neg) begin
            n_hs = $signed({2'b00, n_offset}) - $signed({4'b0000, n_mag});
        end else begin
            n_hs = $signed({2'b00, n_offset}) + $signed({5'b00000, r_hq[2]});
        end
        n_hw  = (n_hs < 0) ? (n_hs + $signed({2'b00, HUE_FULL})) : n_hs;
        n_hue = n_hw[14:0];
        n_sat = r_ctl[2].full ? SAT_MAX : {r_sq[2][11:0], s_st[3].q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue <= r_ctl[2].gray ? 15'd0 : n_hue;
        r_sat <= r_ctl[2].gray ? 16'd0 : n_sat;
        r_sum <= r_ctl[2].sum;
    end

    assign o_valid         = r_out_valid;
    assign o_hue           = r_hue;
    assign o_saturation    = r_sat;
    assign o_lightness_sum = r_sum;

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_hue < HUE_FULL))
        else $error("hue out of range");

    a_hue_needs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_hue != 15'd0)) |-> (r_sat != 16'd0))
        else $error("non-zero hue with zero saturation");

    a_full_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && r_ctl[2].full && !r_ctl[2].gray) |=> (r_sat == SAT_MAX))
        else $error("full spread not saturated");

endmodule

`default_nettype wire

/* sv/rgb_to_hsl_converter.sv */
`timescale 1ns / 1ps
`default_nettype none
// RGB to HSL converter, fixed point, one pixel item per clock.
// Path from the accepting edge to the result strobe o_valid: stages A, B, C0..C2, out.
// Throughput: one item every cycle; busy is high only while reset is held.
// Depth is set by the two 4-bit-per-stage long dividers (saturation, hue).
// Reset: synchronous active low, clears the valid pipeline; data unreset.

module rgb_to_hsl_converter import rhc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    output logic             o_valid,
    output logic [14:0]      o_hue,
    output logic [15:0]      o_saturation,
    output logic [8:0]       o_lightness_sum
);

    // Stage plan:
    //   A  max/min with red-then-green tie break, hue numerator
    //   B  spread, sum, denominator, 15*|num| (3840 = 15 * 256)
    //   C0..C2  four quotient bits per divider per stage
    //   out  last saturation bits, hue floor/offset/wrap, gray forcing
    // The receiver takes every strobe, so the pipeline never halts.

    logic  accept;
    logic  prep_valid;
    t_prep prep;

    // items offered during reset would be flushed, so refuse them
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_valid (prep_valid),
        .o_prep  (prep)
    );

    rhc_divider u_divider (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (prep_valid),
        .i_prep          (prep),
        .o_valid         (o_valid),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_lightness_sum (o_lightness_sum)
    );

    // every accepted item comes out on o_valid after passing all pipeline stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##6 o_valid)
        else $error("item lost in pipeline");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 6))
        else $error("result without an accepted item");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_saturation == 16'd0)) |-> (o_hue == 15'd0))
        else $error("gray item with non-zero hue");

endmodule

`default_nettype wire

/* sim/tb_rgb_to_hsl_converter.sv */
`timescale 1ns / 1ps

// expected HSL triple for one pixel item
typedef struct {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [8:0]  lsum;
} hsl_t;

class hsl_scoreboard;
    localparam int HUE_STEP  = 3840;    // 60 degrees in 1/64 degree
    localparam int HUE_WRAP  = 23040;   // 360 degrees
    localparam int SAT_UNITY = 65536;
    localparam int SAT_CLAMP = 65535;

    hsl_t pending_q[$];
    int   errors;

    function new();
        errors = 0;
    endfunction

    function hsl_t convert(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        int          r, g, b, mx, mn, spread, lsum, num, offs, p, q, hue, denom;
        int unsigned sat;
        rhc_pkg::t_sel win;
        hsl_t        res;
        r = red;
        g = green;
        b = blue;
        // ties go to red, then green
        mx = r;
        win = rhc_pkg::SEL_RED;
        if (g > mx) begin
            mx = g;
            win = rhc_pkg::SEL_GREEN;
        end
        if (b > mx) begin
            mx = b;
            win = rhc_pkg::SEL_BLUE;
        end
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        spread = mx - mn;
        lsum = mx + mn;
        if (spread == 0) begin
            hue = 0;
            sat = 0;
        end else begin
            denom = (lsum <= 255) ? lsum : 510 - lsum;
            sat = (spread * SAT_UNITY) / denom;
            if (sat > SAT_CLAMP) sat = SAT_CLAMP;
            case (win)
                rhc_pkg::SEL_RED: begin
                    num = g - b;
                    offs = 0;
                end
                rhc_pkg::SEL_GREEN: begin
                    num = b - r;
                    offs = 2 * HUE_STEP;
                end
                default: begin
                    num = r - g;
                    offs = 4 * HUE_STEP;
                end
            endcase
            // division rounds towards minus infinity
            p = HUE_STEP * num;
            if (p >= 0) q = p / spread;
            else q = -((-p + spread - 1) / spread);
            hue = q + offs;
            if (hue < 0) hue += HUE_WRAP;
        end
        res.hue = hue[14:0];
        res.sat = sat[15:0];
        res.lsum = lsum[8:0];
        return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pending_q.push_back(convert(r, g, b));
    endfunction

    function void check_result(logic [14:0] hue, logic [15:0] sat, logic [8:0] lsum);
        hsl_t exp_px;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result hue=%0d sat=%0d sum=%0d",
                     $time, hue, sat, lsum);
            errors++;
            return;
        end
        exp_px = pending_q.pop_front();
        if (hue !== exp_px.hue) begin
            $display("%0t: hue expected %0d actual %0d", $time, exp_px.hue, hue);
            errors++;
        end
        if (sat !== exp_px.sat) begin
            $display("%0t: saturation expected %0d actual %0d", $time, exp_px.sat, sat);
            errors++;
        end
        if (lsum !== exp_px.lsum) begin
            $display("%0t: lightness_sum expected %0d actual %0d",
                     $time, exp_px.lsum, lsum);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction
endclass

module tb_rgb_to_hsl_converter;

    localparam int RANDOM_PIXELS = 1800;
    localparam int DRAIN_CYCLES  = 20;      // well past the converter latency

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_red_in;
    logic [7:0]  i_green_in;
    logic [7:0]  i_blue_in;
    logic        o_valid;
    logic [14:0] o_hue;
    logic [15:0] o_saturation;
    logic [8:0]  o_lightness_sum;

    hsl_scoreboard sb;
    int            no_gap_left;   // items left in the current back-to-back burst

    rgb_to_hsl_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .o_valid         (o_valid),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_lightness_sum (o_lightness_sum)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor: everything sampled at the rising edge. The result check runs
    // before the new item is noted, so ordering never hinges on event order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_hue, o_saturation, o_lightness_sum);
            if (start && !busy) sb.note_pixel(i_red_in, i_green_in, i_blue_in);
        end
    end

    // Idle length after an item: mostly none or short, now and then long.
    // Bursts with no idling at all are mixed in.
    function automatic int idle_cycles();
        int pick;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0) begin
            no_gap_left = $urandom_range(20, 60);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Present one item from the falling edge and hold it until accepted;
    // then idle if asked, with junk on the channels while start is low.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input int idle);
        @(negedge i_clk);
        start      <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (idle) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_red_in   <= 8'($urandom);
            i_green_in <= 8'($urandom);
            i_blue_in  <= 8'($urandom);
        end
    endtask

    function automatic logic [7:0] nudge(logic [7:0] base);
        int v;
        v = int'(base) + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic logic [7:0] edge_chan();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            default: return 8'd254;
        endcase
    endfunction

    // Random pixel classes: plain, gray, narrow spread (small divisor),
    // tied maxima, extreme channels and full saturation (min 0 or max 255).
    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
        logic [7:0] base;
        logic [7:0] chans[3];
        int         k;
        base = 8'($urandom);
        chans[0] = 8'($urandom);
        chans[1] = 8'($urandom);
        chans[2] = 8'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4: begin
                chans[0] = base;
                chans[1] = base;
                chans[2] = base;
            end
            5: begin
                chans[0] = nudge(base);
                chans[1] = nudge(base);
                chans[2] = nudge(base);
            end
            6: begin
                // two channels share the top value
                k = $urandom_range(0, 2);
                chans[k] = chans[(k + 1) % 3];
                if (chans[(k + 2) % 3] > chans[k]) chans[(k + 2) % 3] = chans[k] - 8'd1;
            end
            7: begin
                chans[$urandom_range(0, 2)] = edge_chan();
                chans[$urandom_range(0, 2)] = edge_chan();
            end
            default: begin
                chans[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
        endcase
        r = chans[0];
        g = chans[1];
        b = chans[2];
    endtask

    initial begin
        logic [7:0] r, g, b;
        logic [7:0] directed[22][3];
        sb = new();
        no_gap_left = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_red_in   = '0;
        i_green_in = '0;
        i_blue_in  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: black, white, primaries, ties between channels,
        // greys, full saturation at both ends, hue wrapping below zero
        directed = '{
            '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
            '{8'd128, 8'd128, 8'd128}, '{8'd255, 8'd0,   8'd0},
            '{8'd0,   8'd255, 8'd0},   '{8'd0,   8'd0,   8'd255},
            '{8'd255, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd255},
            '{8'd255, 8'd0,   8'd255}, '{8'd1,   8'd0,   8'd0},
            '{8'd255, 8'd254, 8'd254}, '{8'd254, 8'd255, 8'd255},
            '{8'd255, 8'd0,   8'd1},   '{8'd200, 8'd100, 8'd150},
            '{8'd10,  8'd20,  8'd30},  '{8'd1,   8'd2,   8'd3},
            '{8'd30,  8'd20,  8'd10},  '{8'd127, 8'd128, 8'd128},
            '{8'd128, 8'd127, 8'd129}, '{8'd170, 8'd85,  8'd0},
            '{8'd0,   8'd1,   8'd255}, '{8'd100, 8'd200, 8'd200}
        };
        foreach (directed[i])
            send_pixel(directed[i][0], directed[i][1], directed[i][2], idle_cycles());

        repeat (RANDOM_PIXELS) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b, idle_cycles());
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        // catch any stray strobes after the last expected result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
